// ===== hdl/cnsl_pkg.sv =====
// shared types, constants and aes helpers for the scratchpad loop core
package cnsl_pkg;

   localparam int PadLines = 131072;
   localparam int LineBits = $clog2(PadLines);
   localparam int IterBits = 20;
   localparam logic [IterBits-1:0] IterReset = 20'h80000;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_RD1,
      ST_AES,
      ST_WR1,
      ST_RD2,
      ST_MUL,
      ST_WR2,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic load;
      logic read;
      logic rd1;
      logic aes;
      logic wr1;
      logic rd2;
      logic mul;
      logic wr2;
   } cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
       8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
       8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
       8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
       8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
       8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
       8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
       8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
       8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
       8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
       8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
       8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
       8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
       8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
       8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
       8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
       8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // one round: subbytes, shiftrows, mixcolumns, addroundkey
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[r + 4*c] = sbox(s[8*(r + 4*((c + r) % 4)) +: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         o[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         o[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         o[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         o[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return o ^ k;
   endfunction

endpackage

// ===== hdl/cnsl_ctrl.sv =====
// controller state machine for the scratchpad loop core
module cnsl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_op,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [cnsl_pkg::IterBits-1:0] iter_count,
   output cnsl_pkg::cmd_type  cmd
);

   cnsl_pkg::state_type state_ff, state_in;
   logic [cnsl_pkg::IterBits-1:0] rounds_ff, rounds_in;
   logic                          accept;

   assign req_tready = (state_ff == cnsl_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == cnsl_pkg::ST_RESP);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in  = state_ff;
      rounds_in = rounds_ff;
      unique case (state_ff)
         cnsl_pkg::ST_IDLE: begin
            if (accept) begin
               rounds_in = '0;
               unique case (cnsl_pkg::op_type'(req_op))
                  cnsl_pkg::OP_LOAD: state_in = cnsl_pkg::ST_LOAD;
                  cnsl_pkg::OP_READ: state_in = cnsl_pkg::ST_READ;
                  cnsl_pkg::OP_RUN:
                     state_in = (iter_count == '0) ? cnsl_pkg::ST_RESP : cnsl_pkg::ST_RD1;
                  default: state_in = cnsl_pkg::ST_RESP;
               endcase
            end
         end
         cnsl_pkg::ST_LOAD: state_in = cnsl_pkg::ST_RESP;
         cnsl_pkg::ST_READ: state_in = cnsl_pkg::ST_RESP;
         cnsl_pkg::ST_RD1:  state_in = cnsl_pkg::ST_AES;
         cnsl_pkg::ST_AES:  state_in = cnsl_pkg::ST_WR1;
         cnsl_pkg::ST_WR1:  state_in = cnsl_pkg::ST_RD2;
         cnsl_pkg::ST_RD2:  state_in = cnsl_pkg::ST_MUL;
         cnsl_pkg::ST_MUL:  state_in = cnsl_pkg::ST_WR2;
         cnsl_pkg::ST_WR2: begin
            rounds_in = rounds_ff + 1'b1;
            state_in  = (rounds_in == iter_count) ? cnsl_pkg::ST_RESP : cnsl_pkg::ST_RD1;
         end
         cnsl_pkg::ST_RESP: if (rsp_tready) state_in = cnsl_pkg::ST_IDLE;
         default: state_in = cnsl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.start = accept;
      cmd.load  = (state_ff == cnsl_pkg::ST_LOAD);
      cmd.read  = (state_ff == cnsl_pkg::ST_READ);
      cmd.rd1   = (state_ff == cnsl_pkg::ST_RD1);
      cmd.aes   = (state_ff == cnsl_pkg::ST_AES);
      cmd.wr1   = (state_ff == cnsl_pkg::ST_WR1);
      cmd.rd2   = (state_ff == cnsl_pkg::ST_RD2);
      cmd.mul   = (state_ff == cnsl_pkg::ST_MUL);
      cmd.wr2   = (state_ff == cnsl_pkg::ST_WR2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cnsl_pkg::ST_IDLE;
         rounds_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rounds_ff <= rounds_in;
      end
   end

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> !cmd.start) else $error("accept while busy");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr2 |-> rounds_ff < iter_count) else $error("round overrun");

endmodule

// ===== hdl/cnsl_dpath.sv =====
// datapath: scratchpad memory, aes round, multiplier and accumulators
module cnsl_dpath (
   input  logic              clock,
   input  cnsl_pkg::cmd_type cmd,
   input  logic [cnsl_pkg::LineBits-1:0] req_line,
   input  logic [63:0]       req_wlo,
   input  logic [63:0]       req_whi,
   input  logic [63:0]       req_mlo,
   input  logic [63:0]       req_mhi,
   input  logic [1:0]        req_op,
   output logic [63:0]       rsp_lo,
   output logic [63:0]       rsp_hi,
   output logic              rsp_fin
);

   logic [127:0] pad [cnsl_pkg::PadLines];
   logic [127:0] rdata_ff;
   logic [127:0] a_ff, b_ff, c_ff, t_ff;
   logic [63:0]  idx_ff;
   logic [cnsl_pkg::LineBits-1:0] line_ff, addr_ff;
   logic [cnsl_pkg::LineBits-1:0] rd_addr;
   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0]  mid, plo, phi, alo_n, ahi_n;
   logic [127:0] aes_out;
   logic         rd_en, wr_en;
   logic [127:0] wdata;
   logic [63:0]  olo_ff, ohi_ff;
   logic         ofin_ff;

   assign rd_addr = cmd.read ? addr_ff : idx_ff[cnsl_pkg::LineBits+3:4];
   assign rd_en   = cmd.read || cmd.rd1 || cmd.rd2;
   assign wr_en   = cmd.load || cmd.wr1 || cmd.wr2;

   assign aes_out = cnsl_pkg::aes_round(rdata_ff, a_ff);

   assign mid   = {32'd0, ll_ff[63:32]} + {32'd0, lh_ff[31:0]} + {32'd0, hl_ff[31:0]};
   assign plo   = {mid[31:0], ll_ff[31:0]};
   assign phi   = hh_ff + {32'd0, lh_ff[63:32]} + {32'd0, hl_ff[63:32]} + {32'd0, mid[63:32]};
   assign alo_n = a_ff[63:0] + phi;
   assign ahi_n = a_ff[127:64] + plo;

   always_comb begin
      wdata = t_ff;
      if (cmd.wr2) wdata = {ahi_n, alo_n};
   end

   always_ff @(posedge clock) begin
      if (wr_en) pad[line_ff] <= wdata;
      if (rd_en) rdata_ff <= pad[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff <= req_line;
         line_ff <= req_line;
         t_ff    <= {req_whi, req_wlo};
         olo_ff  <= '0;
         ohi_ff  <= '0;
         ofin_ff <= (req_op == cnsl_pkg::OP_RUN);
         if (req_op == cnsl_pkg::OP_RUN) begin
            a_ff   <= {req_whi, req_wlo};
            b_ff   <= {req_mhi, req_mlo};
            idx_ff <= req_wlo;
         end
      end
      if (cmd.read) begin
         olo_ff <= pad[addr_ff][63:0];
         ohi_ff <= pad[addr_ff][127:64];
      end
      if (cmd.rd1) line_ff <= idx_ff[cnsl_pkg::LineBits+3:4];
      if (cmd.aes) begin
         t_ff   <= b_ff ^ aes_out;
         b_ff   <= aes_out;
         c_ff   <= aes_out;
         idx_ff <= aes_out[63:0];
      end
      if (cmd.rd2) line_ff <= idx_ff[cnsl_pkg::LineBits+3:4];
      if (cmd.mul) begin
         ll_ff <= 64'(idx_ff[31:0])  * 64'(rdata_ff[31:0]);
         lh_ff <= 64'(idx_ff[31:0])  * 64'(rdata_ff[63:32]);
         hl_ff <= 64'(idx_ff[63:32]) * 64'(rdata_ff[31:0]);
         hh_ff <= 64'(idx_ff[63:32]) * 64'(rdata_ff[63:32]);
         c_ff  <= rdata_ff;
      end
      if (cmd.wr2) begin
         a_ff   <= {ahi_n, alo_n} ^ c_ff;
         idx_ff <= alo_n ^ c_ff[63:0];
      end
   end

   assign rsp_lo  = olo_ff;
   assign rsp_hi  = ohi_ff;
   assign rsp_fin = ofin_ff;

endmodule

// ===== hdl/cryptonight_scratchpad_loop_core.sv =====
// top level of the scratchpad main loop core
// requests arrive on req_* (tdata = operation, line_index, word_low, word_high,
// mix_low, mix_high from the lowest bit up); each request gives one response on
// rsp_* (tdata = data_low, data_high, finished).
// csr_* writes iteration_count (reset 524288); csr_ready is high only while the
// core is idle and no request is offered.
// a load or read request holds the core through one scratchpad access and the response handshake.
// a run holds it for iteration_count iterations: each iteration is two dependent
// single-port scratchpad read/modify/write passes, an aes round and a
// four-part 64x64 multiply, one register stage each.
// the core takes one request at a time; req_tready is low from acceptance
// until the response is taken.
// a stalled receiver holds rsp_tvalid and the data steady, and keeps the core busy
// until the response is taken.
// reset returns the controller to idle and sets iteration_count to its
// default; scratchpad contents are undefined until written.
module cryptonight_scratchpad_loop_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [279:0] req_tdata,  // operation, line_index, word_low, word_high, mix_low, mix_high
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // data_low, data_high, finished
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [19:0]  csr_data
);

   logic [cnsl_pkg::IterBits-1:0] iter_ff;
   cnsl_pkg::cmd_type cmd;
   logic [63:0] lo, hi;
   logic        fin;

   // the count only changes between requests
   assign csr_ready = req_tready && !req_tvalid;

   always_ff @(posedge clock) begin
      if (reset) iter_ff <= cnsl_pkg::IterReset;
      else if (csr_valid && csr_ready) iter_ff <= csr_data;
   end

   cnsl_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op(req_tdata[1:0]), .rsp_tvalid, .rsp_tready,
      .iter_count(iter_ff), .cmd
   );

   cnsl_dpath u_dpath (
      .clock, .cmd,
      .req_line(req_tdata[2 +: cnsl_pkg::LineBits]),
      .req_wlo(req_tdata[82:19]), .req_whi(req_tdata[146:83]),
      .req_mlo(req_tdata[210:147]), .req_mhi(req_tdata[274:211]),
      .req_op(req_tdata[1:0]),
      .rsp_lo(lo), .rsp_hi(hi), .rsp_fin(fin)
   );

   assign rsp_tdata = {7'd0, fin, hi, lo};

endmodule
